// ===== rtl/pdf_pkg.sv =====
package pdf_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam logic [63:0] PiQ31 = 64'd6746518852;
  localparam logic [30:0] DragCoefReset = 31'd30802;

  typedef enum logic [1:0] {
    PdfOk   = 2'd0,
    PdfZero = 2'd1,
    PdfSat  = 2'd2
  } pdf_status_e;

  typedef struct packed {
    logic [30:0] rho;
    logic [30:0] rad;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] k;
    logic        sat;
    logic        zero;
  } pdf_ctx_t;

  // unsigned fixed-point product, rounded half up and capped; bit 32 flags the cap
  function automatic logic [32:0] pdf_mulq(input logic [31:0] a, input logic [31:0] b,
                                           input int unsigned frac);
    logic [63:0] p;
    logic [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + (64'd1 << (frac - 1))) >> frac;
    if (|r[63:32]) begin
      return {1'b1, 32'hFFFF_FFFF};
    end else begin
      return {1'b0, r[31:0]};
    end
  endfunction

  function automatic logic [31:0] pdf_abs(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

endpackage

// ===== rtl/pdf_coef.sv =====
module pdf_coef #(
  parameter int unsigned FRAC_BITS = pdf_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pdf_pkg::pdf_ctx_t ctx_i,
  input  logic [30:0]      cd_i,
  output logic             valid_o,
  output pdf_pkg::pdf_ctx_t ctx_o
);

  localparam logic [31:0] PiF =
    32'((pdf_pkg::PiQ31 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));

  logic              v1_q, v2_q, v3_q;
  pdf_pkg::pdf_ctx_t ctx1_q, ctx2_q, ctx3_q;
  pdf_pkg::pdf_ctx_t ctx1_d, ctx2_d, ctx3_d;
  logic [31:0]       r2_q, b1_q, a_q, b2_q;
  logic [32:0]       m_r2, m_b, m_a, m_c;

  always_comb begin
    m_r2 = pdf_pkg::pdf_mulq({1'b0, ctx_i.rad}, {1'b0, ctx_i.rad}, FRAC_BITS);
    m_b  = pdf_pkg::pdf_mulq({1'b0, ctx_i.rho}, {1'b0, cd_i}, FRAC_BITS);
    ctx1_d = ctx_i;
    ctx1_d.sat = ctx_i.sat | m_r2[32] | m_b[32];
    m_a = pdf_pkg::pdf_mulq(r2_q, PiF, FRAC_BITS);
    ctx2_d = ctx1_q;
    ctx2_d.sat = ctx1_q.sat | m_a[32];
    m_c = pdf_pkg::pdf_mulq(b2_q, a_q, FRAC_BITS);
    ctx3_d = ctx2_q;
    ctx3_d.sat = ctx2_q.sat | m_c[32];
    ctx3_d.k = 32'((33'(m_c[31:0]) + 33'd1) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q <= ctx1_d;
      r2_q   <= m_r2[31:0];
      b1_q   <= m_b[31:0];
      ctx2_q <= ctx2_d;
      a_q    <= m_a[31:0];
      b2_q   <= b1_q;
      ctx3_q <= ctx3_d;
    end
  end

  assign valid_o = v3_q;
  assign ctx_o   = ctx3_q;

endmodule

// ===== rtl/pdf_div.sv =====
module pdf_div #(
  parameter int unsigned FRAC_BITS = pdf_pkg::FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  pdf_pkg::pdf_ctx_t        ctx_i,
  output logic                     valid_o,
  output pdf_pkg::pdf_ctx_t        ctx_o,
  output logic [32+FRAC_BITS-1:0]  qx_o,
  output logic [32+FRAC_BITS-1:0]  qy_o
);

  localparam int unsigned W = 32 + FRAC_BITS;

  logic              vld_q  [W];
  pdf_pkg::pdf_ctx_t ctx_q  [W];
  logic [30:0]       remx_q [W];
  logic [30:0]       remy_q [W];
  logic [W-1:0]      dqx_q  [W];
  logic [W-1:0]      dqy_q  [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic              vin;
    pdf_pkg::pdf_ctx_t cin;
    logic [30:0]       rxin, ryin;
    logic [W-1:0]      dxin, dyin;
    logic [31:0]       tx, ty;
    logic              gex, gey;

    if (j == 0) begin : g_first
      assign vin  = valid_i;
      assign cin  = ctx_i;
      assign rxin = '0;
      assign ryin = '0;
      assign dxin = {pdf_pkg::pdf_abs(ctx_i.gx), {FRAC_BITS{1'b0}}};
      assign dyin = {pdf_pkg::pdf_abs(ctx_i.gy), {FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign vin  = vld_q[j-1];
      assign cin  = ctx_q[j-1];
      assign rxin = remx_q[j-1];
      assign ryin = remy_q[j-1];
      assign dxin = dqx_q[j-1];
      assign dyin = dqy_q[j-1];
    end

    assign tx  = {rxin, dxin[W-1]};
    assign ty  = {ryin, dyin[W-1]};
    assign gex = tx >= {1'b0, cin.rho};
    assign gey = ty >= {1'b0, cin.rho};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[j]  <= cin;
        remx_q[j] <= gex ? 31'(tx - {1'b0, cin.rho}) : tx[30:0];
        remy_q[j] <= gey ? 31'(ty - {1'b0, cin.rho}) : ty[30:0];
        dqx_q[j]  <= {dxin[W-2:0], gex};
        dqy_q[j]  <= {dyin[W-2:0], gey};
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign ctx_o   = ctx_q[W-1];
  assign qx_o    = dqx_q[W-1];
  assign qy_o    = dqy_q[W-1];

endmodule

// ===== rtl/pdf_vr.sv =====
module pdf_vr #(
  parameter int unsigned FRAC_BITS = pdf_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  pdf_pkg::pdf_ctx_t       ctx_i,
  input  logic [32+FRAC_BITS-1:0] qx_i,
  input  logic [32+FRAC_BITS-1:0] qy_i,
  output logic                    valid_o,
  output pdf_pkg::pdf_ctx_t       ctx_o,
  output logic [63:0]             sum_o
);

  localparam int unsigned W  = 32 + FRAC_BITS;
  localparam int unsigned DW = W + 2;
  localparam logic signed [DW-1:0] SMax = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] SMin = -SMax - DW'(1);

  function automatic logic [32:0] rel_vel(input logic [31:0] v, input logic [W-1:0] q,
                                          input logic neg);
    logic signed [DW-1:0] ve;
    logic signed [DW-1:0] qe;
    logic signed [DW-1:0] d;
    ve = DW'($signed(v));
    qe = $signed({2'b00, q});
    d  = neg ? ve + qe : ve - qe;
    if (d > SMax) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (d < SMin) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, d[31:0]};
    end
  endfunction

  logic              v1_q, v2_q, v3_q;
  pdf_pkg::pdf_ctx_t ctx1_q, ctx2_q, ctx3_q;
  pdf_pkg::pdf_ctx_t ctx1_d;
  logic [32:0]       rx, ry;
  logic [31:0]       avx, avy;
  logic [63:0]       sqx_q, sqy_q, sum_q;

  always_comb begin
    rx = rel_vel(ctx_i.vx, qx_i, ctx_i.gx[31]);
    ry = rel_vel(ctx_i.vy, qy_i, ctx_i.gy[31]);
    ctx1_d = ctx_i;
    ctx1_d.vx = rx[31:0];
    ctx1_d.vy = ry[31:0];
    ctx1_d.sat = ctx_i.sat | rx[32] | ry[32];
    avx = pdf_pkg::pdf_abs(ctx1_q.vx);
    avy = pdf_pkg::pdf_abs(ctx1_q.vy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q <= ctx1_d;
      ctx2_q <= ctx1_q;
      sqx_q  <= 64'(avx) * 64'(avx);
      sqy_q  <= 64'(avy) * 64'(avy);
      ctx3_q <= ctx2_q;
      sum_q  <= sqx_q + sqy_q;
    end
  end

  assign valid_o = v3_q;
  assign ctx_o   = ctx3_q;
  assign sum_o   = sum_q;

endmodule

// ===== rtl/pdf_sqrt.sv =====
module pdf_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pdf_pkg::pdf_ctx_t ctx_i,
  input  logic [63:0]       x_i,
  output logic              valid_o,
  output pdf_pkg::pdf_ctx_t ctx_o,
  output logic [31:0]       root_o
);

  localparam int unsigned N = 32;

  logic              vld_q  [N];
  pdf_pkg::pdf_ctx_t ctx_q  [N];
  logic [33:0]       rem_q  [N];
  logic [31:0]       root_q [N];
  logic [63:0]       x_q    [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic              vin;
    pdf_pkg::pdf_ctx_t cin;
    logic [33:0]       rin;
    logic [31:0]       oin;
    logic [63:0]       xin;
    logic [35:0]       r2, trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign cin = ctx_i;
      assign rin = '0;
      assign oin = '0;
      assign xin = x_i;
    end else begin : g_next
      assign vin = vld_q[j-1];
      assign cin = ctx_q[j-1];
      assign rin = rem_q[j-1];
      assign oin = root_q[j-1];
      assign xin = x_q[j-1];
    end

    assign r2    = {rin, xin[63:62]};
    assign trial = {2'b00, oin, 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[j]  <= cin;
        rem_q[j]  <= ge ? 34'(r2 - trial) : r2[33:0];
        root_q[j] <= {oin[30:0], ge};
        x_q[j]    <= {xin[61:0], 2'b00};
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

// ===== rtl/pdf_force.sv =====
module pdf_force #(
  parameter int unsigned FRAC_BITS = pdf_pkg::FracBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pdf_pkg::pdf_ctx_t ctx_i,
  input  logic [31:0]       n_i,
  output logic              valid_o,
  output logic [31:0]       force_x_o,
  output logic [31:0]       force_y_o,
  output logic [1:0]        status_o
);

  function automatic logic [32:0] finish(input logic [63:0] p, input logic [31:0] vr);
    logic [63:0] r;
    logic [31:0] mag;
    logic        s;
    r = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    s = 1'b0;
    if (r > 64'h8000_0000) begin
      mag = 32'h8000_0000;
      s = 1'b1;
    end else begin
      mag = r[31:0];
    end
    if (!vr[31] && (|vr)) begin
      return {s, 32'(-mag)};
    end else if (mag == 32'h8000_0000) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else begin
      return {s, mag};
    end
  endfunction

  logic                 v1_q, v2_q, v3_q;
  pdf_pkg::pdf_ctx_t    ctx1_q, ctx2_q;
  pdf_pkg::pdf_ctx_t    ctx1_d;
  logic [32:0]          mm;
  logic [31:0]          m_q;
  logic [63:0]          px_q, py_q;
  logic [32:0]          fx, fy;
  logic [31:0]          force_x_d, force_y_d, force_x_q, force_y_q;
  pdf_pkg::pdf_status_e status_d, status_q;

  always_comb begin
    mm = pdf_pkg::pdf_mulq(ctx_i.k, n_i, FRAC_BITS);
    ctx1_d = ctx_i;
    ctx1_d.sat = ctx_i.sat | mm[32];
    fx = finish(px_q, ctx2_q.vx);
    fy = finish(py_q, ctx2_q.vy);
    if (ctx2_q.zero) begin
      force_x_d = '0;
      force_y_d = '0;
      status_d  = pdf_pkg::PdfZero;
    end else begin
      force_x_d = fx[31:0];
      force_y_d = fy[31:0];
      status_d  = (ctx2_q.sat | fx[32] | fy[32]) ? pdf_pkg::PdfSat : pdf_pkg::PdfOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q    <= ctx1_d;
      m_q       <= mm[31:0];
      ctx2_q    <= ctx1_q;
      px_q      <= 64'(m_q) * 64'(pdf_pkg::pdf_abs(ctx1_q.vx));
      py_q      <= 64'(m_q) * 64'(pdf_pkg::pdf_abs(ctx1_q.vy));
      force_x_q <= force_x_d;
      force_y_q <= force_y_d;
      status_q  <= status_d;
    end
  end

  assign valid_o   = v3_q;
  assign force_x_o = force_x_q;
  assign force_y_o = force_y_q;
  assign status_o  = status_q;

endmodule

// ===== rtl/particle_drag_force.sv =====
// Quadratic drag force on a sphere, one particle per transaction.
// Input channel: in_valid_i / in_ready_o with density, momentum, velocity
// and radius; momentum and velocity signed Q(32-F).F, density and radius
// unsigned Q(31-F).F. Output channel: out_valid_o / out_ready_i with
// force_x_o, force_y_o and status_o (0 ok, 1 zero density, 2 saturated).
// cfg_we_i writes cfg_wdata_i into the drag coefficient; write it only
// while no transaction is in flight.
// Pipeline depth comes from the restoring divider, one quotient bit per
// stage (32 + FRAC_BITS stages), and the square root, one result bit
// per stage (32 stages).
// Throughput: one transaction per cycle while the output does not stall.
// Reset clears all valid bits and loads the coefficient with 0.47 at the
// default FRAC_BITS.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready_o drops; nothing is lost or repeated.
module particle_drag_force #(
  parameter int unsigned FRAC_BITS = pdf_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] fluid_density_i,
  input  logic [31:0] fluid_momentum_x_i,
  input  logic [31:0] fluid_momentum_y_i,
  input  logic [31:0] particle_vel_x_i,
  input  logic [31:0] particle_vel_y_i,
  input  logic [30:0] particle_radius_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] force_x_o,
  output logic [31:0] force_y_o,
  output logic [1:0]  status_o
);

  localparam int unsigned W = 32 + FRAC_BITS;

  logic [30:0]       drag_coef_q;
  logic              en;
  pdf_pkg::pdf_ctx_t ctx_in, ctx_c, ctx_d, ctx_v, ctx_s;
  logic              val_c, val_d, val_v, val_s;
  logic [W-1:0]      qx, qy;
  logic [63:0]       sum;
  logic [31:0]       root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_coef_q <= pdf_pkg::DragCoefReset;
    end else if (cfg_we_i) begin
      drag_coef_q <= cfg_wdata_i;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    ctx_in      = '0;
    ctx_in.rho  = fluid_density_i;
    ctx_in.rad  = particle_radius_i;
    ctx_in.gx   = fluid_momentum_x_i;
    ctx_in.gy   = fluid_momentum_y_i;
    ctx_in.vx   = particle_vel_x_i;
    ctx_in.vy   = particle_vel_y_i;
    ctx_in.zero = fluid_density_i == '0;
  end

  pdf_coef #(.FRAC_BITS(FRAC_BITS)) u_coef (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .ctx_i(ctx_in), .cd_i(drag_coef_q),
    .valid_o(val_c), .ctx_o(ctx_c)
  );

  pdf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(val_c), .ctx_i(ctx_c),
    .valid_o(val_d), .ctx_o(ctx_d), .qx_o(qx), .qy_o(qy)
  );

  pdf_vr #(.FRAC_BITS(FRAC_BITS)) u_vr (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(val_d), .ctx_i(ctx_d), .qx_i(qx), .qy_i(qy),
    .valid_o(val_v), .ctx_o(ctx_v), .sum_o(sum)
  );

  pdf_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(val_v), .ctx_i(ctx_v), .x_i(sum),
    .valid_o(val_s), .ctx_o(ctx_s), .root_o(root)
  );

  pdf_force #(.FRAC_BITS(FRAC_BITS)) u_force (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(val_s), .ctx_i(ctx_s), .n_i(root),
    .valid_o(out_valid_o), .force_x_o, .force_y_o, .status_o
  );

`ifndef NO_ASSERTIONS
  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pdf_pkg::PdfZero |-> force_x_o == '0 && force_y_o == '0)
    else $error("zero-density result carries a nonzero force");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_ready_tracks_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalls");
`endif

endmodule
